>>> hdl/pdmdec_pkg.sv
// Shared widths, types, constants and FIR coefficients for the PDM decimator.
package pdmdec_pkg;

  // Defaults for the top-level parameters.
  localparam int DECIMATION_DEF = 64;
  localparam int CIC_STAGES_DEF = 5;

  // Fixed field and datapath widths.
  localparam int PDM_W     = 8;
  localparam int PCM_W     = 16;
  localparam int CIC_W     = 32;
  localparam int PDM_STEP  = 32;

  // Compensation FIR: 15 symmetric taps, folded into 8 products.
  localparam int FIR_TAPS  = 15;
  localparam int FIR_HALF  = 8;
  localparam int COEF_W    = 11;
  localparam int PRE_W     = PCM_W + 1;
  localparam int ACC_W     = 28;
  localparam int FIR_SHIFT = 10;
  localparam int SH_W      = ACC_W - FIR_SHIFT;

  localparam int PCM_MAX   = 32767;
  localparam int PCM_MIN   = -32768;

  typedef logic signed [CIC_W-1:0] cic_word_t;
  typedef logic signed [PCM_W-1:0] pcm_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Flags that travel with each bit down the integrator chain.
  typedef struct packed {
    logic vld;
    logic dec;
  } cic_tag_t;

  // Folded coefficient j multiplies taps j and FIR_TAPS-1-j (the center tap alone).
  function automatic coef_t fir_coef(input logic [2:0] idx);
    coef_t c;
    c = '0;
    case (idx)
      3'd0:    c = -COEF_W'(18);
      3'd1:    c = -COEF_W'(42);
      3'd2:    c = -COEF_W'(80);
      3'd3:    c = -COEF_W'(110);
      3'd4:    c = -COEF_W'(98);
      3'd5:    c = COEF_W'(12);
      3'd6:    c = COEF_W'(256);
      3'd7:    c = COEF_W'(512);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/pdmdec_integ_cell.sv
// One CIC integrator cell: adds its neighbor's value for every valid bit.
module pdmdec_integ_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  pdmdec_pkg::cic_tag_t    tag_in,
  input  pdmdec_pkg::cic_word_t   x_in,
  output pdmdec_pkg::cic_tag_t    tag_out,
  output pdmdec_pkg::cic_word_t   acc_out
);

  pdmdec_pkg::cic_tag_t  tag_r;
  pdmdec_pkg::cic_word_t acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
      acc_r <= '0;
    end else if (en) begin
      tag_r <= tag_in;
      if (tag_in.vld) begin
        acc_r <= acc_r + x_in;
      end
    end
  end

  assign tag_out = tag_r;
  assign acc_out = acc_r;

endmodule

>>> hdl/pdmdec_comb_cell.sv
// One CIC comb cell: differences its input against the previous decimated value.
module pdmdec_comb_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_in,
  input  pdmdec_pkg::cic_word_t   v_in,
  output logic                    vld_out,
  output pdmdec_pkg::cic_word_t   d_out
);

  logic                  vld_r;
  pdmdec_pkg::cic_word_t dly_r;
  pdmdec_pkg::cic_word_t d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      dly_r <= '0;
    end else if (en) begin
      vld_r <= vld_in;
      if (vld_in) begin
        dly_r <= v_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_in) begin
      d_r <= v_in - dly_r;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

>>> hdl/pdmdec_fir.sv
// Symmetric 15-tap compensation FIR: tap line, pre-add, multiply and a registered adder tree.
module pdmdec_fir (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  smp_vld,
  input  pdmdec_pkg::pcm_t      smp,
  output logic                  res_vld,
  output pdmdec_pkg::acc_t      res
);

  localparam int TAPS = pdmdec_pkg::FIR_TAPS;
  localparam int HALF = pdmdec_pkg::FIR_HALF;
  localparam int PW   = pdmdec_pkg::PRE_W;
  localparam int AW   = pdmdec_pkg::ACC_W;

  // Tap line, oldest sample at index 0.
  pdmdec_pkg::pcm_t     line_r [TAPS];
  logic signed [PW-1:0] pre_r  [HALF];
  pdmdec_pkg::acc_t     prod_r [HALF];
  pdmdec_pkg::acc_t     sum4_r [4];
  pdmdec_pkg::acc_t     sum2_r [2];
  pdmdec_pkg::acc_t     sum1_r;

  logic line_vld_r, pre_vld_r, prod_vld_r, sum4_vld_r, sum2_vld_r, sum1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        line_r[i] <= '0;
      end
    end else if (en && smp_vld) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[TAPS-1] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_vld_r <= 1'b0;
      pre_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
      sum4_vld_r <= 1'b0;
      sum2_vld_r <= 1'b0;
      sum1_vld_r <= 1'b0;
    end else if (en) begin
      line_vld_r <= smp_vld;
      pre_vld_r  <= line_vld_r;
      prod_vld_r <= pre_vld_r;
      sum4_vld_r <= prod_vld_r;
      sum2_vld_r <= sum4_vld_r;
      sum1_vld_r <= sum2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < HALF - 1; j++) begin
        pre_r[j] <= PW'(line_r[j]) + PW'(line_r[TAPS-1-j]);
      end
      pre_r[HALF-1] <= PW'(line_r[HALF-1]);
      for (int j = 0; j < HALF; j++) begin
        prod_r[j] <= AW'(pre_r[j]) * AW'(pdmdec_pkg::fir_coef(3'(j)));
      end
      for (int j = 0; j < 4; j++) begin
        sum4_r[j] <= prod_r[2*j] + prod_r[2*j+1];
      end
      for (int j = 0; j < 2; j++) begin
        sum2_r[j] <= sum4_r[2*j] + sum4_r[2*j+1];
      end
      sum1_r <= sum2_r[0] + sum2_r[1];
    end
  end

  assign res_vld = sum1_vld_r;
  assign res     = sum1_r;

endmodule

>>> hdl/pdm_cic_decimator_fir.sv
// Top level of the PDM-to-PCM decimator: CIC integrator and comb chains and compensation FIR.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   in_pdm_byte    (8 PDM bits, MSB first)
//   out_      output     out_valid / out_ready out_pcm_sample (signed 16-bit PCM)
//
// A byte is sent into the integrator chain one bit per cycle while the
// pipeline is not frozen; a new byte is taken in the cycle its predecessor's
// last bit leaves. The bit that completes a decimation period then passes
// the integrator and comb cells, the FIR's tap line, pre-add, product and
// adder-tree registers and the output register. Reset (synchronous, active
// low) clears the integrator sums, comb delays, FIR tap line, counters and
// valid flags. While a finished sample waits in the output register and
// out_ready is low, the whole pipeline freezes and in_ready stays low.
module pdm_cic_decimator_fir #(
  parameter int DECIMATION = pdmdec_pkg::DECIMATION_DEF,
  parameter int CIC_STAGES = pdmdec_pkg::CIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pdmdec_pkg::PDM_W-1:0]       in_pdm_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pdmdec_pkg::PCM_W-1:0] out_pcm_sample
);

  localparam int PDM_W  = pdmdec_pkg::PDM_W;
  localparam int CIC_W  = pdmdec_pkg::CIC_W;
  localparam int PCM_W  = pdmdec_pkg::PCM_W;
  localparam int SH_W   = pdmdec_pkg::SH_W;
  localparam int ACC_W  = pdmdec_pkg::ACC_W;
  localparam int BCNT_W = $clog2(DECIMATION);
  localparam int SCNT_W = $clog2(PDM_W + 1);

  localparam pdmdec_pkg::cic_word_t STEP_POS = CIC_W'(pdmdec_pkg::PDM_STEP);
  localparam pdmdec_pkg::cic_word_t STEP_NEG = -CIC_W'(pdmdec_pkg::PDM_STEP);
  localparam logic signed [SH_W-1:0] SAT_HI  = SH_W'(pdmdec_pkg::PCM_MAX);
  localparam logic signed [SH_W-1:0] SAT_LO  = SH_W'(pdmdec_pkg::PCM_MIN);

  // Global advance: every stage moves unless a sample is stuck at the output.
  logic en;
  logic out_valid_r;
  pdmdec_pkg::pcm_t out_pcm_r;

  assign en = !out_valid_r || out_ready;

  // Bit shifter: holds the current byte and the number of bits still to send.
  logic [PDM_W-1:0]  bits_r;
  logic [SCNT_W-1:0] scnt_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic              issue;
  logic              dec_now;
  logic              in_acc;

  assign issue    = (scnt_r != '0);
  assign in_ready = en && (scnt_r <= SCNT_W'(1));
  assign in_acc   = in_valid && in_ready;
  assign dec_now  = (bcnt_r == BCNT_W'(DECIMATION - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_r <= '0;
      bcnt_r <= '0;
    end else if (en) begin
      if (in_acc) begin
        scnt_r <= SCNT_W'(PDM_W);
      end else if (issue) begin
        scnt_r <= scnt_r - SCNT_W'(1);
      end
      if (issue) begin
        bcnt_r <= dec_now ? '0 : bcnt_r + BCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_acc) begin
        bits_r <= in_pdm_byte;
      end else if (issue) begin
        bits_r <= {bits_r[PDM_W-2:0], 1'b0};
      end
    end
  end

  // Integrator chain. Each cell sees its neighbor's registered sum, so every
  // bit ripples through the chain stage by stage, one register per cell, and
  // the decimation flag travels along with it.
  pdmdec_pkg::cic_tag_t  int_tag [CIC_STAGES+1];
  pdmdec_pkg::cic_word_t int_acc [CIC_STAGES+1];

  assign int_tag[0].vld = issue;
  assign int_tag[0].dec = dec_now;
  assign int_acc[0]     = bits_r[PDM_W-1] ? STEP_POS : STEP_NEG;

  for (genvar k = 0; k < CIC_STAGES; k++) begin : g_integ
    pdmdec_integ_cell u_integ (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .tag_in  (int_tag[k]),
      .x_in    (int_acc[k]),
      .tag_out (int_tag[k+1]),
      .acc_out (int_acc[k+1])
    );
  end

  // Comb chain, fed only with the last integrator's value at decimation points.
  logic                  comb_vld [CIC_STAGES+1];
  pdmdec_pkg::cic_word_t comb_v   [CIC_STAGES+1];

  assign comb_vld[0] = int_tag[CIC_STAGES].vld && int_tag[CIC_STAGES].dec;
  assign comb_v[0]   = int_acc[CIC_STAGES];

  for (genvar k = 0; k < CIC_STAGES; k++) begin : g_comb
    pdmdec_comb_cell u_comb (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (comb_vld[k]),
      .v_in    (comb_v[k]),
      .vld_out (comb_vld[k+1]),
      .d_out   (comb_v[k+1])
    );
  end

  // The arithmetic shift by 16 of a 32-bit word always fits 16 bits, so the
  // upper half is the sample and needs no clamp.
  pdmdec_pkg::pcm_t cic_smp;
  assign cic_smp = comb_v[CIC_STAGES][CIC_W-1 -: PCM_W];

  logic                fir_vld;
  pdmdec_pkg::acc_t    fir_acc;

  pdmdec_fir u_fir (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .smp_vld (comb_vld[CIC_STAGES]),
    .smp     (cic_smp),
    .res_vld (fir_vld),
    .res     (fir_acc)
  );

  // Floor shift by 10 is the upper bits of the sum; then saturate to 16 bits.
  logic signed [SH_W-1:0] fir_sh;
  pdmdec_pkg::pcm_t       fir_sat;

  assign fir_sh = $signed(fir_acc[ACC_W-1:pdmdec_pkg::FIR_SHIFT]);

  always_comb begin
    if (fir_sh > SAT_HI) begin
      fir_sat = PCM_W'(SAT_HI);
    end else if (fir_sh < SAT_LO) begin
      fir_sat = PCM_W'(SAT_LO);
    end else begin
      fir_sat = PCM_W'(fir_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fir_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en && fir_vld) begin
      out_pcm_r <= fir_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pcm_sample = out_pcm_r;

endmodule

>>> hdl/pdmdec_checker.sv
// Port-level checks for the PDM decimator, bound to the top level.
module pdmdec_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [pdmdec_pkg::PDM_W-1:0]        in_pdm_byte,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [pdmdec_pkg::PCM_W-1:0] out_pcm_sample
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pcm_sample))
    else $error("stalled result changed or vanished");

  // A waiting result freezes the pipeline, so no new byte may be taken.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // A byte occupies the bit shifter after its transaction, so in_ready drops.
  a_byte_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready again right after a transaction");

  // An offered byte stays in place until its transaction completes.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_pdm_byte))
    else $error("offered byte changed or withdrawn before acceptance");

endmodule

bind pdm_cic_decimator_fir pdmdec_checker u_pdmdec_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_pdm_byte    (in_pdm_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pcm_sample (out_pcm_sample)
);
